[src/xxh32_pkg.sv]
// xxh32_pkg: shared types, primes and helpers for the streaming xxh32 block
// used by xxh32_ctrl, xxh32_dp and xxhash32_stream; no other dependencies
`timescale 1ns / 1ps

package xxh32_pkg;

  localparam logic [31:0] PRIME1 = 32'h9E37_79B1;
  localparam logic [31:0] PRIME2 = 32'h85EB_CA77;
  localparam logic [31:0] PRIME3 = 32'hC2B2_AE3D;
  localparam logic [31:0] PRIME4 = 32'h27D4_EB2F;
  localparam logic [31:0] PRIME5 = 32'h1656_67B1;

  localparam logic [31:0] SEED_RESET = PRIME1;
  // lane 0 starts at seed + prime 1 + prime 2, modulo 2^32
  localparam logic [31:0] LANE0_BIAS = PRIME1 + PRIME2;

  localparam logic [2:0] FULL_COUNT = 3'd4;
  localparam logic [1:0] STRIPE_FILL = 2'd3;
  localparam logic [1:0] LAST_LANE = 2'd3;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LANE_MUL,
    OP_LANE_ACC,
    OP_CONV_A,
    OP_CONV_B,
    OP_PEND_MUL,
    OP_PEND_ACC,
    OP_BYTE_MUL,
    OP_BYTE_ACC,
    OP_AV1,
    OP_AV2,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LANE_MUL,
    ST_LANE_ACC,
    ST_CONV_A,
    ST_CONV_B,
    ST_PEND_MUL,
    ST_PEND_ACC,
    ST_BYTE_MUL,
    ST_BYTE_ACC,
    ST_AV1,
    ST_AV2,
    ST_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic stripe_go;  // incoming item completes a stripe
    logic in_last;    // incoming item closes the message
    logic cur_last;   // item in work closes the message
    logic has_pend;
    logic pend_end;
    logic has_bytes;
    logic byte_end;
    logic lane_end;
    logic out_free;
  } dp_sts_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

[src/xxh32_ctrl.sv]
// xxh32_ctrl: sequencer for the xxh32 datapath
// depends on xxh32_pkg for the state, command and status types
`timescale 1ns / 1ps

module xxh32_ctrl import xxh32_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    in_stall
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.accept = 1'b0;
    cmd.op     = OP_NONE;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.stripe_go) begin
            state_next = ST_LANE_MUL;
          end else if (sts.in_last) begin
            state_next = ST_CONV_A;
          end
        end
      end
      ST_LANE_MUL: begin
        cmd.op     = OP_LANE_MUL;
        state_next = ST_LANE_ACC;
      end
      ST_LANE_ACC: begin
        cmd.op = OP_LANE_ACC;
        if (!sts.lane_end) begin
          state_next = ST_LANE_MUL;
        end else if (sts.cur_last) begin
          state_next = ST_CONV_A;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CONV_A: begin
        cmd.op     = OP_CONV_A;
        state_next = ST_CONV_B;
      end
      ST_CONV_B: begin
        cmd.op = OP_CONV_B;
        if (sts.has_pend) begin
          state_next = ST_PEND_MUL;
        end else if (sts.has_bytes) begin
          state_next = ST_BYTE_MUL;
        end else begin
          state_next = ST_AV1;
        end
      end
      ST_PEND_MUL: begin
        cmd.op     = OP_PEND_MUL;
        state_next = ST_PEND_ACC;
      end
      ST_PEND_ACC: begin
        cmd.op = OP_PEND_ACC;
        if (!sts.pend_end) begin
          state_next = ST_PEND_MUL;
        end else if (sts.has_bytes) begin
          state_next = ST_BYTE_MUL;
        end else begin
          state_next = ST_AV1;
        end
      end
      ST_BYTE_MUL: begin
        cmd.op     = OP_BYTE_MUL;
        state_next = ST_BYTE_ACC;
      end
      ST_BYTE_ACC: begin
        cmd.op     = OP_BYTE_ACC;
        state_next = sts.byte_end ? ST_AV1 : ST_BYTE_MUL;
      end
      ST_AV1: begin
        cmd.op     = OP_AV1;
        state_next = ST_AV2;
      end
      ST_AV2: begin
        cmd.op     = OP_AV2;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // wait here while the previous hash is still held downstream
        if (sts.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/xxh32_dp.sv]
// xxh32_dp: lanes, pending words, length, shared multiplier and output register
// depends on xxh32_pkg for primes, rotate helper and command/status types
`timescale 1ns / 1ps

module xxh32_dp import xxh32_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [31:0] seed_data,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  input  logic        out_stall,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  output logic        out_valid,
  output logic [31:0] hash_value
);

  logic [31:0] seed;
  logic [31:0] lane [4];
  logic [31:0] pend [3];
  logic [1:0]  pend_cnt;
  logic [31:0] byte_len;
  logic        long_msg;
  logic        fresh;
  logic [31:0] cur_word;
  logic [2:0]  cur_cnt;
  logic        cur_last;
  logic [1:0]  idx;
  logic [31:0] prod;
  logic [31:0] h;
  logic [31:0] hash_reg;

  logic [2:0]  cnt_sat;
  logic [1:0]  pend_eff;
  logic [31:0] len_base;
  logic [31:0] pend_w;
  logic [31:0] lane_w;
  logic [7:0]  byte_sel;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_lo;
  logic        out_free;

  // an item that is not last always counts four bytes
  assign cnt_sat  = (!last || byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
  assign pend_eff = fresh ? 2'd0 : pend_cnt;
  assign len_base = fresh ? 32'd0 : byte_len;

  always_comb begin
    case (idx)
      2'd0:    pend_w = pend[0];
      2'd1:    pend_w = pend[1];
      2'd2:    pend_w = pend[2];
      default: pend_w = 32'd0;
    endcase
  end

  assign lane_w   = (idx == LAST_LANE) ? cur_word : pend_w;
  assign byte_sel = 8'(cur_word >> {idx, 3'b000});

  // one shared multiplier, low word only
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (cmd.op)
      OP_LANE_MUL: begin
        mul_a = lane_w;
        mul_b = PRIME2;
      end
      OP_LANE_ACC: begin
        mul_a = rotl32(lane[idx] + prod, 13);
        mul_b = PRIME1;
      end
      OP_PEND_MUL: begin
        mul_a = pend_w;
        mul_b = PRIME3;
      end
      OP_PEND_ACC: begin
        mul_a = rotl32(h + prod, 17);
        mul_b = PRIME4;
      end
      OP_BYTE_MUL: begin
        mul_a = {24'd0, byte_sel};
        mul_b = PRIME5;
      end
      OP_BYTE_ACC: begin
        mul_a = rotl32(h + prod, 11);
        mul_b = PRIME1;
      end
      OP_AV1: begin
        mul_a = h ^ (h >> 15);
        mul_b = PRIME2;
      end
      OP_AV2: begin
        mul_a = h ^ (h >> 13);
        mul_b = PRIME3;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_lo   = mul_a * mul_b;
  assign out_free = !out_valid || !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= SEED_RESET;
      pend_cnt  <= 2'd0;
      byte_len  <= 32'd0;
      long_msg  <= 1'b0;
      fresh     <= 1'b1;
      cur_cnt   <= 3'd0;
      cur_last  <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (seed_we) begin
        seed <= seed_data;
      end
      if (cmd.accept) begin
        cur_cnt  <= cnt_sat;
        cur_last <= last;
        idx      <= 2'd0;
        byte_len <= len_base + {29'd0, cnt_sat};
        fresh    <= 1'b0;
        if (fresh) begin
          long_msg <= 1'b0;
        end
        if (cnt_sat == FULL_COUNT) begin
          if (pend_eff == STRIPE_FILL) begin
            pend_cnt <= 2'd0;
            long_msg <= 1'b1;
          end else begin
            pend_cnt <= pend_eff + 2'd1;
          end
        end else begin
          pend_cnt <= pend_eff;
        end
      end
      unique case (cmd.op)
        OP_LANE_ACC, OP_BYTE_ACC: begin
          idx <= idx + 2'd1;
        end
        OP_PEND_ACC: begin
          idx <= sts.pend_end ? 2'd0 : idx + 2'd1;
        end
        OP_CONV_B: begin
          idx <= 2'd0;
        end
        OP_EMIT: begin
          fresh    <= 1'b1;
          pend_cnt <= 2'd0;
        end
        default: begin
        end
      endcase
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_word <= data_word;
      if (fresh) begin
        lane[0] <= seed + LANE0_BIAS;
        lane[1] <= seed + PRIME2;
        lane[2] <= seed;
        lane[3] <= seed - PRIME1;
      end
      if (cnt_sat == FULL_COUNT && pend_eff != STRIPE_FILL) begin
        pend[pend_eff] <= data_word;
      end
    end
    unique case (cmd.op)
      OP_LANE_MUL, OP_PEND_MUL, OP_BYTE_MUL: begin
        prod <= mul_lo;
      end
      OP_LANE_ACC: begin
        lane[idx] <= mul_lo;
      end
      OP_PEND_ACC, OP_BYTE_ACC, OP_AV1, OP_AV2: begin
        h <= mul_lo;
      end
      OP_CONV_A: begin
        h <= long_msg ? rotl32(lane[0], 1) + rotl32(lane[1], 7) + rotl32(lane[2], 12)
                      : seed + PRIME5;
      end
      OP_CONV_B: begin
        h <= h + byte_len + (long_msg ? rotl32(lane[3], 18) : 32'd0);
      end
      OP_EMIT: begin
        hash_reg <= h ^ (h >> 16);
      end
      default: begin
      end
    endcase
  end

  assign hash_value = hash_reg;

  always_comb begin
    sts.stripe_go = (cnt_sat == FULL_COUNT) && (pend_eff == STRIPE_FILL);
    sts.in_last   = last;
    sts.cur_last  = cur_last;
    sts.has_pend  = (pend_cnt != 2'd0);
    sts.pend_end  = (idx == pend_cnt - 2'd1);
    sts.has_bytes = !cur_cnt[2] && (cur_cnt != 3'd0);
    sts.byte_end  = (idx == cur_cnt[1:0] - 2'd1);
    sts.lane_end  = (idx == LAST_LANE);
    sts.out_free  = out_free;
  end

endmodule

[src/xxhash32_stream.sv]
// a word that closes neither a stripe nor the message is taken with no stall; the word that
// closes a stripe runs four lane rounds of two multiplier passes each; a last item then
// runs the two converge steps, a pass pair per pending word and per tail byte, and the
// three finish steps before the hash shows; all rounds share one 32x32 multiplier
// reset: synchronous, seed back to its default, no message open, no hash held
// top level: xxh32_ctrl sequencer plus xxh32_dp datapath, types from xxh32_pkg
`timescale 1ns / 1ps

module xxhash32_stream import xxh32_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // seed register write port
  input  logic        seed_we,
  input  logic [31:0] seed_data,
  // message words in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  // hash out
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash_value
);

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // the sequencer takes an item only when idle; the hash sits in its own
  // output register so a new message can start while it waits downstream
  xxh32_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // lanes load from the seed on the first item of each message; the short
  // message start uses the seed register as it stands at the converge step
  xxh32_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .seed_we    (seed_we),
    .seed_data  (seed_data),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .hash_value (hash_value)
  );

endmodule
